// ----- hw/rtl/lsf_pkg.sv -----
// Shared types and constants for the least-squares line fit block.
`default_nettype none
package lsf_pkg;

  localparam int CNT_MAX_W = 17;   // widest sample count over the parameter range
  localparam int SUM_W     = 64;   // width of a sum handed to the fit engine
  localparam int PROD_W    = 128;  // width of a full product
  localparam int SHIFT_W   = 5;    // width of a divider scale shift

  typedef enum logic [1:0] {
    FIT_OK   = 2'd0,
    FIT_FEW  = 2'd1,
    FIT_FLAT = 2'd2
  } fit_status_t;

  // Finished sums of one set, as the front hands them to the fit engine.
  typedef struct packed {
    logic [CNT_MAX_W-1:0]    count;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sxx;
    logic signed [SUM_W-1:0] syy;
    logic signed [SUM_W-1:0] sxy;
  } snap_t;

  typedef struct packed {
    logic [31:0]          slope;
    logic [31:0]          icpt;
    logic [16:0]          r2;
    fit_status_t          status;
    logic [CNT_MAX_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] a;
    logic signed [SUM_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [PROD_W-1:0]  num;
    logic [SHIFT_W-1:0] shift;
    logic [PROD_W-1:0]  den;
  } div_req_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lsf_front.sv -----
// Front end: takes sample items and keeps the exact count and sums of a set.
`default_nettype none
module lsf_front #(
  parameter int MAX_POINTS = 1024
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire signed [15:0]   in_x_value,
  input  wire signed [15:0]   in_y_value,
  input  wire                 in_last_point,
  input  wire                 q_full,
  output logic                q_push,
  output lsf_pkg::snap_t      q_snap
);
  import lsf_pkg::*;

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int SXW = CW + 16;
  localparam int SQW = CW + 31;

  logic [CW-1:0]         cnt_r, cnt_nxt, cnt_add;
  logic signed [SXW-1:0] sx_r, sx_nxt, sx_add, sy_r, sy_nxt, sy_add;
  logic signed [SQW-1:0] sxx_r, sxx_nxt, sxx_add, syy_r, syy_nxt, syy_add;
  logic signed [SQW-1:0] sxy_r, sxy_nxt, sxy_add;
  logic signed [31:0]    xx, yy, xy;
  logic                  fire, take;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign take     = cnt_r < CW'(MAX_POINTS);
  assign xx       = in_x_value * in_x_value;
  assign yy       = in_y_value * in_y_value;
  assign xy       = in_x_value * in_y_value;

  always_comb begin
    cnt_add = cnt_r;
    sx_add  = sx_r;
    sy_add  = sy_r;
    sxx_add = sxx_r;
    syy_add = syy_r;
    sxy_add = sxy_r;
    if (take) begin
      cnt_add = cnt_r + CW'(1);
      sx_add  = sx_r + SXW'(in_x_value);
      sy_add  = sy_r + SXW'(in_y_value);
      sxx_add = sxx_r + SQW'(xx);
      syy_add = syy_r + SQW'(yy);
      sxy_add = sxy_r + SQW'(xy);
    end
    q_push       = fire && in_last_point;
    q_snap.count = CNT_MAX_W'(cnt_add);
    q_snap.sx    = SUM_W'(sx_add);
    q_snap.sy    = SUM_W'(sy_add);
    q_snap.sxx   = SUM_W'(sxx_add);
    q_snap.syy   = SUM_W'(syy_add);
    q_snap.sxy   = SUM_W'(sxy_add);
    cnt_nxt = cnt_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    sxx_nxt = sxx_r;
    syy_nxt = syy_r;
    sxy_nxt = sxy_r;
    if (fire) begin
      if (in_last_point) begin
        cnt_nxt = '0;
        sx_nxt  = '0;
        sy_nxt  = '0;
        sxx_nxt = '0;
        syy_nxt = '0;
        sxy_nxt = '0;
      end else begin
        cnt_nxt = cnt_add;
        sx_nxt  = sx_add;
        sy_nxt  = sy_add;
        sxx_nxt = sxx_add;
        syy_nxt = syy_add;
        sxy_nxt = sxy_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sxx_r <= sxx_nxt;
      syy_r <= syy_nxt;
      sxy_r <= sxy_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lsf_fifo.sv -----
// Two-entry queue of finished set sums between front and fit engine.
`default_nettype none
module lsf_fifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  lsf_pkg::snap_t  din,
  output logic            full,
  input  wire             pop,
  output lsf_pkg::snap_t  dout,
  output logic            empty
);
  import lsf_pkg::*;

  snap_t      ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = ~wp_r;
    if (pop) rp_nxt = ~rp_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lsf_mul.sv -----
// Shift-and-add signed multiplier, one multiplier bit per cycle.
`default_nettype none
module lsf_mul (
  input  wire                clk,
  input  wire                rst_n,
  input  lsf_pkg::mul_req_t  req,
  output logic               done,
  output logic [127:0]       prod
);
  import lsf_pkg::*;

  logic              busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [PROD_W-1:0] ma_r, ma_nxt, acc_r, acc_nxt, p_r, p_nxt;
  logic [SUM_W-1:0]  mb_r, mb_nxt, mag_a, mag_b;

  assign done  = done_r;
  assign prod  = p_r;
  assign mag_a = req.a[SUM_W-1] ? SUM_W'(0) - req.a : req.a;
  assign mag_b = req.b[SUM_W-1] ? SUM_W'(0) - req.b : req.b;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    p_nxt    = p_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.a[SUM_W-1] ^ req.b[SUM_W-1];
      ma_nxt   = PROD_W'(mag_a);
      mb_nxt   = mag_b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (mb_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        p_nxt    = neg_r ? PROD_W'(0) - acc_r : acc_r;
      end else begin
        if (mb_r[0]) acc_nxt = acc_r + ma_r;
        ma_nxt = {ma_r[PROD_W-2:0], 1'b0};
        mb_nxt = {1'b0, mb_r[SUM_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    p_r   <= p_nxt;
    neg_r <= neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lsf_div.sv -----
// Restoring long divider: floor(num * 2^shift / den), quotient clamped at 2^32.
`default_nettype none
module lsf_div (
  input  wire                clk,
  input  wire                rst_n,
  input  lsf_pkg::div_req_t  req,
  output logic               done,
  output logic [32:0]        quo
);
  import lsf_pkg::*;

  localparam logic [33:0] Q_CLAMP = 34'h1_0000_0000;

  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [PROD_W-1:0] num_r, num_nxt, den_r, den_nxt, rem_r, rem_nxt;
  logic [PROD_W:0]   trial;
  logic              ge;
  logic [33:0]       qs;
  logic [32:0]       q_r, q_nxt;

  assign done  = done_r;
  assign quo   = q_r;
  assign trial = {rem_r, num_r[PROD_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign qs    = {q_r, ge};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 8'(PROD_W) + 8'(req.shift);
      num_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? PROD_W'(trial - {1'b0, den_r}) : trial[PROD_W-1:0];
      q_nxt   = (qs > Q_CLAMP) ? Q_CLAMP[32:0] : qs[32:0];
      num_nxt = {num_r[PROD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 8'd1;
      if (cnt_r == 8'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lsf_back.sv -----
// Fit engine: sequences the shared multiplier and divider over one set's sums.
`default_nettype none
module lsf_back (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             snap_valid,
  input  lsf_pkg::snap_t  snap,
  output logic            snap_pop,
  output logic            out_valid,
  input  wire             out_ready,
  output lsf_pkg::res_t   res
);
  import lsf_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_NXX   = 16'h0002,
    S_SXX   = 16'h0004,
    S_NYY   = 16'h0008,
    S_SYY   = 16'h0010,
    S_NXY   = 16'h0020,
    S_SXY   = 16'h0040,
    S_YXX   = 16'h0080,
    S_XXY   = 16'h0100,
    S_SLOPE = 16'h0200,
    S_ICPT  = 16'h0400,
    S_CXY2  = 16'h0800,
    S_CXCY  = 16'h1000,
    S_R2    = 16'h2000,
    S_MEAN  = 16'h4000,
    S_OUT   = 16'h8000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    issued_r, issued_nxt;
  snap_t                   sn_r, sn_nxt;
  logic signed [SUM_W-1:0] cxx_r, cxx_nxt, cyy_r, cyy_nxt, cxy_r, cxy_nxt;
  logic [PROD_W-1:0]       t1_r, t1_nxt, t2_r, t2_nxt;
  logic [31:0]             slope_r, slope_nxt, icpt_r, icpt_nxt;
  logic [16:0]             r2_r, r2_nxt;
  fit_status_t             status_r, status_nxt;
  res_t                    out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  mul_req_t                mul_req;
  div_req_t                div_req;
  logic                    mul_op, div_op, mul_done, div_done, div_neg;
  logic signed [SUM_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]       mul_p, div_num_s, div_den;
  logic [SHIFT_W-1:0]      div_shift;
  logic [32:0]             div_q;
  logic                    cxx_pos, cyy_pos;

  function automatic logic [31:0] sat32(input logic neg, input logic [32:0] q);
    logic [32:0] m;
    begin
      if (!neg) begin
        sat32 = (q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end else begin
        m     = (q > 33'h0_8000_0000) ? 33'h0_8000_0000 : q;
        sat32 = 32'(33'd0 - m);
      end
    end
  endfunction

  lsf_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_p)
  );

  lsf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_q)
  );

  assign cxx_pos   = !cxx_r[SUM_W-1] && (cxx_r != '0);
  assign cyy_pos   = !cyy_r[SUM_W-1] && (cyy_r != '0);
  assign out_valid = out_valid_r;
  assign res       = out_r;

  // Operand selection for the step in progress.
  always_comb begin
    mul_op    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_op    = 1'b0;
    div_num_s = '0;
    div_den   = '0;
    div_shift = '0;
    unique case (state_r)
      S_NXX:   begin mul_op = 1'b1; mul_a = SUM_W'(sn_r.count); mul_b = sn_r.sxx; end
      S_SXX:   begin mul_op = 1'b1; mul_a = sn_r.sx; mul_b = sn_r.sx; end
      S_NYY:   begin mul_op = 1'b1; mul_a = SUM_W'(sn_r.count); mul_b = sn_r.syy; end
      S_SYY:   begin mul_op = 1'b1; mul_a = sn_r.sy; mul_b = sn_r.sy; end
      S_NXY:   begin mul_op = 1'b1; mul_a = SUM_W'(sn_r.count); mul_b = sn_r.sxy; end
      S_SXY:   begin mul_op = 1'b1; mul_a = sn_r.sx; mul_b = sn_r.sy; end
      S_YXX:   begin mul_op = 1'b1; mul_a = sn_r.sy; mul_b = sn_r.sxx; end
      S_XXY:   begin mul_op = 1'b1; mul_a = sn_r.sx; mul_b = sn_r.sxy; end
      S_CXY2:  begin mul_op = 1'b1; mul_a = cxy_r; mul_b = cxy_r; end
      S_CXCY:  begin mul_op = 1'b1; mul_a = cxx_r; mul_b = cyy_r; end
      S_SLOPE: begin
        div_op = 1'b1; div_num_s = PROD_W'(cxy_r);
        div_den = PROD_W'($unsigned(cxx_r)); div_shift = SHIFT_W'(16);
      end
      S_ICPT:  begin
        div_op = 1'b1; div_num_s = t2_r;
        div_den = PROD_W'($unsigned(cxx_r)); div_shift = SHIFT_W'(6);
      end
      S_MEAN:  begin
        div_op = 1'b1; div_num_s = PROD_W'(sn_r.sy);
        div_den = PROD_W'(sn_r.count); div_shift = SHIFT_W'(6);
      end
      S_R2:    begin
        div_op = 1'b1; div_num_s = t1_r; div_den = t2_r; div_shift = SHIFT_W'(16);
      end
      default: begin
        mul_op = 1'b0;
      end
    endcase
    div_neg       = (state_r != S_R2) && div_num_s[PROD_W-1];
    mul_req.start = mul_op && !issued_r;
    mul_req.a     = mul_a;
    mul_req.b     = mul_b;
    div_req.start = div_op && !issued_r;
    div_req.num   = div_neg ? PROD_W'(0) - div_num_s : div_num_s;
    div_req.shift = div_shift;
    div_req.den   = div_den;
  end

  // Sequencer: capture each step's result and advance.
  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    sn_nxt        = sn_r;
    cxx_nxt       = cxx_r;
    cyy_nxt       = cyy_r;
    cxy_nxt       = cxy_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    slope_nxt     = slope_r;
    icpt_nxt      = icpt_r;
    r2_nxt        = r2_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    snap_pop      = 1'b0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    if (mul_op || div_op) issued_nxt = !(mul_done || div_done);

    unique case (state_r)
      S_IDLE: begin
        if (snap_valid) begin
          snap_pop  = 1'b1;
          sn_nxt    = snap;
          slope_nxt = '0;
          icpt_nxt  = '0;
          r2_nxt    = '0;
          if (snap.count < CNT_MAX_W'(2)) begin
            status_nxt = FIT_FEW;
            state_nxt  = S_OUT;
          end else begin
            status_nxt = FIT_OK;
            state_nxt  = S_NXX;
          end
        end
      end
      S_NXX: if (mul_done) begin t1_nxt = mul_p; state_nxt = S_SXX; end
      S_SXX: if (mul_done) begin
        cxx_nxt = t1_r[SUM_W-1:0] - mul_p[SUM_W-1:0]; state_nxt = S_NYY;
      end
      S_NYY: if (mul_done) begin t1_nxt = mul_p; state_nxt = S_SYY; end
      S_SYY: if (mul_done) begin
        cyy_nxt = t1_r[SUM_W-1:0] - mul_p[SUM_W-1:0]; state_nxt = S_NXY;
      end
      S_NXY: if (mul_done) begin t1_nxt = mul_p; state_nxt = S_SXY; end
      S_SXY: if (mul_done) begin
        cxy_nxt   = t1_r[SUM_W-1:0] - mul_p[SUM_W-1:0];
        state_nxt = cxx_pos ? S_YXX : S_MEAN;
      end
      S_YXX: if (mul_done) begin t1_nxt = mul_p; state_nxt = S_XXY; end
      S_XXY: if (mul_done) begin t2_nxt = t1_r - mul_p; state_nxt = S_SLOPE; end
      S_SLOPE: if (div_done) begin
        slope_nxt = sat32(div_neg, div_q); state_nxt = S_ICPT;
      end
      S_ICPT: if (div_done) begin
        icpt_nxt  = sat32(div_neg, div_q);
        state_nxt = cyy_pos ? S_CXY2 : S_OUT;
      end
      S_CXY2: if (mul_done) begin t1_nxt = mul_p; state_nxt = S_CXCY; end
      S_CXCY: if (mul_done) begin t2_nxt = mul_p; state_nxt = S_R2; end
      S_R2: if (div_done) begin
        r2_nxt    = (div_q > 33'd65536) ? 17'h1_0000 : div_q[16:0];
        state_nxt = S_OUT;
      end
      S_MEAN: if (div_done) begin
        icpt_nxt   = sat32(div_neg, div_q);
        status_nxt = FIT_FLAT;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.slope  = slope_r;
          out_nxt.icpt   = icpt_r;
          out_nxt.r2     = r2_r;
          out_nxt.status = status_r;
          out_nxt.count  = sn_r.count;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    sn_r     <= sn_nxt;
    cxx_r    <= cxx_nxt;
    cyy_r    <= cyy_nxt;
    cxy_r    <= cxy_nxt;
    t1_r     <= t1_nxt;
    t2_r     <= t2_nxt;
    slope_r  <= slope_nxt;
    icpt_r   <= icpt_nxt;
    r2_r     <= r2_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/least_squares_line_fit_top.sv -----
// Top level of the streaming least-squares straight-line fit.
`default_nettype none
// Streams (x, y) samples in signed Q5.10, one item per clock while in_ready
// is high, and fits y = slope * x + intercept over each set closed by an
// item with in_last_point high. The front accumulates the exact count and
// sums of x, y, x*x, y*y and x*y as each item is taken, so samples are taken
// at full rate; samples past MAX_POINTS in a set are dropped from the sums. A
// closed set's sums go into a two-entry queue, and the fit engine works them
// off while the front already gathers the next set. The engine runs the fit
// on one shift-and-add multiplier (one multiplier bit a cycle, for each of up
// to ten products) and one restoring divider (one quotient bit a cycle, for
// each of up to three quotients), so the time one set takes in the engine
// depends on the operand sizes and the fit status. in_ready drops only while
// the queue holds two sets that wait for the engine. Each result is held in
// an output register until taken: slope and intercept in saturated Q15.16,
// R squared in unsigned Q1.16, status (ok, fewer than two points, zero x
// variance) and the point count.
module least_squares_line_fit_top #(
  parameter int MAX_POINTS = 1024
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire signed [15:0]                  in_x_value,
  input  wire signed [15:0]                  in_y_value,
  input  wire                                in_last_point,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [31:0]                 out_slope_out,
  output logic signed [31:0]                 out_intercept_out,
  output logic [16:0]                        out_r_squared_out,
  output logic [1:0]                         out_fit_status,
  output logic [$clog2(MAX_POINTS + 1)-1:0]  out_point_count
);
  import lsf_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);

  logic  q_push, q_full, q_empty, q_pop;
  snap_t q_din, q_dout;
  res_t  res;

  // Front: accumulate, close the set on the last item.
  lsf_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_x_value   (in_x_value),
    .in_y_value   (in_y_value),
    .in_last_point(in_last_point),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_snap       (q_din)
  );

  // Hold closed sets until the engine is free.
  lsf_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  // Engine: compute the fit and drive the result register.
  lsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_valid(!q_empty),
    .snap      (q_dout),
    .snap_pop  (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_slope_out     = $signed(res.slope);
  assign out_intercept_out = $signed(res.icpt);
  assign out_r_squared_out = res.r2;
  assign out_fit_status    = res.status;
  assign out_point_count   = res.count[CW-1:0];

  // A closed set never vanishes: it sits in the queue unless popped at once.
  a_set_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_point && !q_pop) |=> !q_empty)
    else $error("closed set missing from queue");

  // Any status other than ok carries no R squared.
  a_r2_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fit_status != FIT_OK) |-> (out_r_squared_out == 17'd0))
    else $error("R squared set on a degenerate fit");

  // Too few points: all numeric results zero and the count below two.
  a_few_points: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fit_status == FIT_FEW) |->
      (out_slope_out == 32'sd0 && out_intercept_out == 32'sd0 &&
       res.count < CNT_MAX_W'(2)))
    else $error("nonzero result on a set of fewer than two points");

endmodule
`default_nettype wire

// ----- verif/tb_least_squares_line_fit_top.sv -----
// Testbench for the streaming least-squares line fit: directed table, random sets, scoreboard.
module tb_least_squares_line_fit_top;
  import lsf_pkg::*;

  localparam int MAX_PTS   = 1024;
  localparam int CNT_W     = $clog2(MAX_PTS + 1);
  localparam int IDLE_LIMIT = 20000;  // cycles with no item moving on either side
  localparam int HOLD_OFF  = 3000;    // long receiver hold-off, in cycles
  localparam int DRAIN     = 2000;    // quiet cycles after the last fit

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_x_value;
  logic signed [15:0] in_y_value;
  logic in_last_point;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_slope_out;
  logic signed [31:0] out_intercept_out;
  logic [16:0] out_r_squared_out;
  logic [1:0] out_fit_status;
  logic [CNT_W-1:0] out_point_count;

  least_squares_line_fit_top #(.MAX_POINTS(MAX_PTS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x_value(in_x_value), .in_y_value(in_y_value), .in_last_point(in_last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_slope_out(out_slope_out), .out_intercept_out(out_intercept_out),
    .out_r_squared_out(out_r_squared_out), .out_fit_status(out_fit_status),
    .out_point_count(out_point_count)
  );

  // One fit result as the block should report it.
  typedef struct {
    logic [31:0]      slope;
    logic [31:0]      icpt;
    logic [16:0]      r2;
    fit_status_t      status;
    logic [CNT_W-1:0] count;
  } fit_t;

  // One row of the directed table; typed rows carry a result read off by hand.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    bit                 typed;
    fit_t               fit;
  } row_t;

  fit_t expected_fits[$];
  int   n_errors;
  int   n_items;
  int   n_fits;
  int   n_few, n_flat, n_ok;
  int   idle_cycles;
  bit   hold_done;

  // Running sums of the open set, kept exactly.
  longint set_n, set_sx, set_sy, set_sxx, set_syy, set_sxy;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Saturate a wide quotient to the signed 32-bit result range.
  function automatic logic [31:0] sat32(input logic signed [127:0] q);
    if (q > 128'sd2147483647) return 32'h7fff_ffff;
    if (q < -128'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  // Fold one sample into the open set; on the last mark, work out the fit
  // and clear the sums.
  function automatic fit_t fold_sample(input logic signed [15:0] x,
                                       input logic signed [15:0] y,
                                       input logic last, output bit closed);
    fit_t f;
    longint xs, ys, cxx, cyy, cxy;
    logic signed [127:0] num, den, q;
    logic [127:0] r2n, r2d, r2q;
    xs = x;
    ys = y;
    closed = 1'b0;
    f.slope = '0; f.icpt = '0; f.r2 = '0; f.status = FIT_FEW; f.count = '0;
    // Hold the sums once the set is full; a marked sample still closes it.
    if (set_n < MAX_PTS) begin
      set_n++;
      set_sx += xs; set_sy += ys;
      set_sxx += xs * xs; set_syy += ys * ys; set_sxy += xs * ys;
    end
    if (!last) return f;
    closed = 1'b1;
    f.count = set_n[CNT_W-1:0];
    if (set_n >= 2) begin
      cxx = set_n * set_sxx - set_sx * set_sx;
      cyy = set_n * set_syy - set_sy * set_sy;
      cxy = set_n * set_sxy - set_sx * set_sy;
      if (cxx <= 0) begin
        // Flat x: intercept is the mean of y, moved from Q5.10 to Q15.16.
        f.status = FIT_FLAT;
        num = set_sy;
        den = set_n;
        q = (num <<< 6) / den;
        f.icpt = sat32(q);
      end else begin
        f.status = FIT_OK;
        den = cxx;
        num = cxy;
        f.slope = sat32((num <<< 16) / den);
        num = 128'(signed'(set_sy)) * 128'(signed'(set_sxx));
        q   = 128'(signed'(set_sx)) * 128'(signed'(set_sxy));
        num = num - q;
        f.icpt = sat32((num <<< 6) / den);
        if (cyy > 0) begin
          r2n = (cxy < 0) ? 128'(-cxy) : 128'(cxy);
          r2n = (r2n * r2n) << 16;
          r2d = 128'(cxx) * 128'(cyy);
          r2q = r2n / r2d;
          f.r2 = (r2q > 128'd65536) ? 17'd65536 : r2q[16:0];
        end
      end
    end
    set_n = 0; set_sx = 0; set_sy = 0; set_sxx = 0; set_syy = 0; set_sxy = 0;
    return f;
  endfunction

  // Offer one item and hold it until taken; update the predictor on acceptance.
  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic last, input bit typed, input fit_t typed_fit);
    fit_t f;
    bit closed;
    in_valid      <= 1'b1;
    in_x_value    <= x;
    in_y_value    <= y;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    n_items++;
    f = fold_sample(x, y, last, closed);
    if (closed) expected_fits.insert(expected_fits.size(), typed ? typed_fit : f);
  endtask

  // Close out a burst with a random gap now and then.
  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random sample value: mostly full range, sometimes extremes or small.
  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Compare one taken result with the oldest expected one.
  always @(posedge clk) begin
    fit_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_fits.size() == 0) begin
        $error("unexpected result: slope %h intercept %h", out_slope_out, out_intercept_out);
        n_errors++;
      end else begin
        e = expected_fits.pop_front();
        n_fits++;
        case (e.status)
          FIT_FEW:  n_few++;
          FIT_FLAT: n_flat++;
          default:  n_ok++;
        endcase
        if (out_slope_out !== e.slope) begin
          $error("slope_out: expected %h, got %h", e.slope, out_slope_out);
          n_errors++;
        end
        if (out_intercept_out !== e.icpt) begin
          $error("intercept_out: expected %h, got %h", e.icpt, out_intercept_out);
          n_errors++;
        end
        if (out_r_squared_out !== e.r2) begin
          $error("r_squared_out: expected %0d, got %0d", e.r2, out_r_squared_out);
          n_errors++;
        end
        if (out_fit_status !== e.status) begin
          $error("fit_status: expected %0d, got %0d", e.status, out_fit_status);
          n_errors++;
        end
        if (out_point_count !== e.count) begin
          $error("point_count: expected %0d, got %0d", e.count, out_point_count);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, ready-only stretches, and one long hold-off once
  // enough items went in, so the set queue fills and in_ready drops.
  initial begin
    int run;
    out_ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && n_items > 120) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      run = $urandom_range(1, 40);
      case ($urandom_range(0, 2))
        0: begin
          out_ready <= 1'b1;
          repeat (run) @(posedge clk);
        end
        1: begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end
        default: begin
          repeat (run) begin
            out_ready <= ($urandom_range(0, 2) != 0);
            @(posedge clk);
          end
        end
      endcase
    end
  end

  // Stimulus.
  initial begin
    row_t rows[$];
    row_t r;
    fit_t f;
    int len, kind;
    logic signed [15:0] cx, cy;
    in_valid <= 1'b0;
    in_x_value <= '0;
    in_y_value <= '0;
    in_last_point <= 1'b0;
    rst_n <= 1'b0;
    n_errors = 0; n_items = 0; n_fits = 0;
    n_few = 0; n_flat = 0; n_ok = 0;
    idle_cycles = 0;
    set_n = 0; set_sx = 0; set_sy = 0; set_sxx = 0; set_syy = 0; set_sxy = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. Typed rows: a lone marked sample gives too few points.
    f.slope = '0; f.icpt = '0; f.r2 = '0; f.status = FIT_FEW; f.count = 1;
    r = '{16'sh7fff, 16'sh8000, 1'b1, 1'b1, f}; rows.insert(rows.size(), r);
    r = '{16'sh8000, 16'sh7fff, 1'b1, 1'b1, f}; rows.insert(rows.size(), r);
    f.count = 0;
    // Exact line y = 2x through three points.
    r = '{16'sd0,    16'sd0,    1'b0, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sd1024, 16'sd2048, 1'b0, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sd2048, 16'sd4096, 1'b1, 1'b0, f}; rows.insert(rows.size(), r);
    // Zero x variance: intercept is the mean of y.
    r = '{16'sh8000, 16'sh7fff, 1'b0, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sh8000, 16'sh8000, 1'b0, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sh8000, -16'sd3,   1'b1, 1'b0, f}; rows.insert(rows.size(), r);
    // Zero y variance: R squared 0, slope 0.
    r = '{16'sd0,    16'sd5,    1'b0, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sd1,    16'sd5,    1'b1, 1'b0, f}; rows.insert(rows.size(), r);
    // Extremes both ways, steep slope to hit saturation.
    r = '{16'sh8000, 16'sh8000, 1'b0, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sh7fff, 16'sh7fff, 1'b1, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sh8000, 16'sh7fff, 1'b0, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sh7fff, 16'sh8000, 1'b1, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sd0,    16'sh8000, 1'b0, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sd1,    16'sh7fff, 1'b1, 1'b0, f}; rows.insert(rows.size(), r);
    // Noisy small set with a large intercept.
    r = '{-16'sd7,   16'sh7000, 1'b0, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sd3,    16'sh7ff0, 1'b0, 1'b0, f}; rows.insert(rows.size(), r);
    r = '{16'sd9,    16'sh6000, 1'b1, 1'b0, f}; rows.insert(rows.size(), r);
    foreach (rows[i]) begin
      send_sample(rows[i].x, rows[i].y, rows[i].last, rows[i].typed, rows[i].fit);
      maybe_gap();
    end

    // Random sets: mostly well-formed sets of a few points, some lone or
    // flat ones.
    while (n_items < 390) begin
      kind = $urandom_range(0, 9);
      len = (kind == 0) ? 1 : $urandom_range(2, 12);
      cx = pick_value();
      cy = pick_value();
      for (int k = 0; k < len; k++) begin
        send_sample((kind == 1) ? cx : pick_value(), (kind == 2) ? cy : pick_value(),
                    k == len - 1, 1'b0, f);
        maybe_gap();
      end
    end
    for (int k = 0; k < 5; k++) begin
      send_sample(pick_value(), pick_value(), k == 4, 1'b0, f);
    end
    in_valid <= 1'b0;

    while (expected_fits.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d samples in %0d fits: %0d ok, %0d too few, %0d flat x",
             n_items, n_fits, n_ok, n_few, n_flat);
    $display("receiver held off %0d cycles once while the sender kept offering items",
             HOLD_OFF);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lsf_pkg.sv
hw/rtl/lsf_front.sv
hw/rtl/lsf_fifo.sv
hw/rtl/lsf_mul.sv
hw/rtl/lsf_div.sv
hw/rtl/lsf_back.sv
hw/rtl/least_squares_line_fit_top.sv
verif/tb_least_squares_line_fit_top.sv
